// File: hw/rtl/okte_pkg.sv
// Shared types, widths and codes for the ordered keyed table engine.
// No dependencies; imported by okte_text_clip and the core top level.
`timescale 1ns / 1ps

package okte_pkg;

    localparam int BYTE_W      = 8;
    localparam int NAME_BYTES  = 29;
    localparam int KIND_BYTES  = 19;
    localparam int NAME_W      = NAME_BYTES * BYTE_W;
    localparam int KIND_W      = KIND_BYTES * BYTE_W;
    localparam int AMOUNT_W    = 16;
    localparam int FUNC_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int SLOT_W      = 4;
    localparam int OCC_W       = 5;
    localparam int WORD_W      = 64;
    localparam int NAME3_W     = 40;
    localparam int KIND2_W     = 24;
    localparam int DEF_CAPACITY = 16;

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [NAME_W-1:0]   key;
        logic [KIND_W-1:0]   kind;
        logic [AMOUNT_W-1:0] amount;
    } t_entry;

endpackage

// File: hw/rtl/ordered_keyed_table_engine_core.sv
// Ordered keyed table engine core: entry memory, scan and compaction sequencer.
// Depends on okte_pkg and okte_text_clip.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                  Payload
// request   in         i_in_valid / o_in_ready    i_func, i_name_0..3, i_kind_0..2, i_amount
// result    out        o_out_valid / i_out_ready  o_status, o_slot, o_found_kind_0..2,
//                                                 o_found_amount, o_occupancy
//
// One item is worked on at a time; the entry memory has one write port and one
// read port with a registered read. Insert and unused codes go straight to done.
// Search: one entry read per cycle while scanning, below the entry count only.
// Remove scans the same way and reports a miss at the end; on a hit the read of the entry
// after the match is already in flight, so each later entry moves down one place
// per cycle right behind the scan. An empty table answers without a scan.
// Reset clears only the entry count and control state; the memory is never read
// at or above the count. A stalled result holds in the output register while the
// next item is already taken; the sequencer waits only if a second result is ready.

module ordered_keyed_table_engine_core #(
    parameter int CAPACITY = okte_pkg::DEF_CAPACITY
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [okte_pkg::FUNC_W-1:0]     i_func,
    input  logic [okte_pkg::WORD_W-1:0]     i_name_0,
    input  logic [okte_pkg::WORD_W-1:0]     i_name_1,
    input  logic [okte_pkg::WORD_W-1:0]     i_name_2,
    input  logic [okte_pkg::NAME3_W-1:0]    i_name_3,
    input  logic [okte_pkg::WORD_W-1:0]     i_kind_0,
    input  logic [okte_pkg::WORD_W-1:0]     i_kind_1,
    input  logic [okte_pkg::KIND2_W-1:0]    i_kind_2,
    input  logic [okte_pkg::AMOUNT_W-1:0]   i_amount,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [okte_pkg::STATUS_W-1:0]   o_status,
    output logic [okte_pkg::SLOT_W-1:0]     o_slot,
    output logic [okte_pkg::WORD_W-1:0]     o_found_kind_0,
    output logic [okte_pkg::WORD_W-1:0]     o_found_kind_1,
    output logic [okte_pkg::KIND2_W-1:0]    o_found_kind_2,
    output logic [okte_pkg::AMOUNT_W-1:0]   o_found_amount,
    output logic [okte_pkg::OCC_W-1:0]      o_occupancy
);
    import okte_pkg::*;

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;  // entry index
    localparam int CW = $clog2(CAPACITY + 1);                   // count 0..CAPACITY

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_FIND  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    // clipped request payload, straight from the ports
    logic [NAME_W-1:0] w_name;
    logic [KIND_W-1:0] w_kind;

    okte_text_clip #(.NBYTES(NAME_BYTES)) u_name_clip (
        .i_text ({i_name_3, i_name_2, i_name_1, i_name_0}),
        .o_text (w_name)
    );

    okte_text_clip #(.NBYTES(KIND_BYTES)) u_kind_clip (
        .i_text ({i_kind_2, i_kind_1, i_kind_0}),
        .o_text (w_kind)
    );

    // entry memory
    t_entry           r_mem [CAPACITY];
    t_entry           r_mem_q;
    logic             w_rd_en;
    logic [IW-1:0]    w_rd_addr;
    logic             w_wr_en;
    logic [IW-1:0]    w_wr_addr;
    t_entry           w_wr_data;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_mem_q <= r_mem[w_rd_addr];
        end
    end

    // control and work registers
    logic [1:0]            r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic [CW-1:0]         r_rd_idx, n_rd_idx;
    logic                  r_pend, n_pend;
    logic [IW-1:0]         r_pend_idx, n_pend_idx;
    logic [FUNC_W-1:0]     r_func, n_func;
    logic [NAME_W-1:0]     r_key, n_key;
    logic [STATUS_W-1:0]   r_res_status, n_res_status;
    logic [IW-1:0]         r_res_slot, n_res_slot;
    logic [KIND_W-1:0]     r_res_kind, n_res_kind;
    logic [AMOUNT_W-1:0]   r_res_amount, n_res_amount;

    // output register
    logic                  r_out_valid, n_out_valid;
    logic [STATUS_W-1:0]   r_out_status, n_out_status;
    logic [SLOT_W-1:0]     r_out_slot, n_out_slot;
    logic [KIND_W-1:0]     r_out_kind, n_out_kind;
    logic [AMOUNT_W-1:0]   r_out_amount, n_out_amount;
    logic [OCC_W-1:0]      r_out_occ, n_out_occ;

    logic w_in_acc;
    logic w_match;
    logic w_scan;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_match    = (r_mem_q.key == r_key);
    assign w_scan     = (r_state == S_FIND) || (r_state == S_SHIFT);

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_rd_idx     = r_rd_idx;
        n_pend       = 1'b0;
        n_pend_idx   = r_pend_idx;
        n_func       = r_func;
        n_key        = r_key;
        n_res_status = r_res_status;
        n_res_slot   = r_res_slot;
        n_res_kind   = r_res_kind;
        n_res_amount = r_res_amount;

        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_status = r_out_status;
        n_out_slot   = r_out_slot;
        n_out_kind   = r_out_kind;
        n_out_amount = r_out_amount;
        n_out_occ    = r_out_occ;

        // walk reads one entry a cycle below the count while scanning
        w_rd_en   = w_scan && (r_rd_idx < r_count);
        w_rd_addr = r_rd_idx[IW-1:0];
        w_wr_en   = 1'b0;
        w_wr_addr = r_count[IW-1:0];
        w_wr_data = '{key: w_name, kind: w_kind, amount: i_amount};

        if (w_rd_en) begin
            n_pend     = 1'b1;
            n_pend_idx = r_rd_idx[IW-1:0];
            n_rd_idx   = r_rd_idx + 1'b1;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_func       = i_func;
                    n_key        = w_name;
                    n_res_status = STATUS_OK;
                    n_res_slot   = '0;
                    n_res_kind   = '0;
                    n_res_amount = '0;
                    n_rd_idx     = '0;
                    n_state      = S_DONE;
                    case (i_func)
                        FUNC_INSERT: begin
                            if (r_count >= CW'(CAPACITY)) begin
                                n_res_status = STATUS_FULL;
                            end else begin
                                // append at the end of the table
                                w_wr_en    = 1'b1;
                                n_res_slot = r_count[IW-1:0];
                                n_count    = r_count + 1'b1;
                            end
                        end
                        FUNC_REMOVE: begin
                            if (r_count == '0) begin
                                n_res_status = STATUS_EMPTY;
                            end else begin
                                n_state = S_FIND;
                            end
                        end
                        FUNC_SEARCH: begin
                            if (r_count == '0) begin
                                n_res_status = STATUS_NOT_FOUND;
                            end else begin
                                n_state = S_FIND;
                            end
                        end
                        default: begin
                            n_res_status = STATUS_OK;
                        end
                    endcase
                end
            end
            S_FIND: begin
                if (r_pend) begin
                    if (w_match) begin
                        n_res_slot = r_pend_idx;
                        if (r_func == FUNC_SEARCH) begin
                            n_res_kind   = r_mem_q.kind;
                            n_res_amount = r_mem_q.amount;
                            n_state      = S_DONE;
                        end else begin
                            // the read of the next entry is already in flight
                            n_state = S_SHIFT;
                        end
                    end else if (!w_rd_en) begin
                        n_res_status = STATUS_NOT_FOUND;
                        n_state      = S_DONE;
                    end
                end
            end
            S_SHIFT: begin
                if (r_pend) begin
                    // move the entry just read down one place
                    w_wr_en   = 1'b1;
                    w_wr_addr = r_pend_idx - 1'b1;
                    w_wr_data = r_mem_q;
                end else begin
                    n_count = r_count - 1'b1;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_slot   = SLOT_W'(r_res_slot);
                    n_out_kind   = r_res_kind;
                    n_out_amount = r_res_amount;
                    n_out_occ    = OCC_W'(r_count);
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rd_idx    <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rd_idx    <= n_rd_idx;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_idx   <= n_pend_idx;
        r_func       <= n_func;
        r_key        <= n_key;
        r_res_status <= n_res_status;
        r_res_slot   <= n_res_slot;
        r_res_kind   <= n_res_kind;
        r_res_amount <= n_res_amount;
        r_out_status <= n_out_status;
        r_out_slot   <= n_out_slot;
        r_out_kind   <= n_out_kind;
        r_out_amount <= n_out_amount;
        r_out_occ    <= n_out_occ;
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_slot         = r_out_slot;
    assign o_found_kind_0 = r_out_kind[WORD_W-1:0];
    assign o_found_kind_1 = r_out_kind[2*WORD_W-1:WORD_W];
    assign o_found_kind_2 = r_out_kind[KIND_W-1:2*WORD_W];
    assign o_found_amount = r_out_amount;
    assign o_occupancy    = r_out_occ;

endmodule

// File: hw/rtl/okte_text_clip.sv
// Text clip: zero every byte after the first zero byte of a packed string.
// Depends on okte_pkg for the byte width and default length.
`timescale 1ns / 1ps

module okte_text_clip #(
    parameter int NBYTES = okte_pkg::NAME_BYTES
) (
    input  logic [NBYTES*okte_pkg::BYTE_W-1:0] i_text,
    output logic [NBYTES*okte_pkg::BYTE_W-1:0] o_text
);
    import okte_pkg::*;

    logic [NBYTES-1:0] w_nz;
    logic [NBYTES-1:0] w_keep;

    always_comb begin
        for (int b = 0; b < NBYTES; b++) begin
            w_nz[b] = |i_text[b*BYTE_W +: BYTE_W];
        end
        // keep a byte only while no earlier byte terminated the string
        for (int b = 0; b < NBYTES; b++) begin
            w_keep[b] = 1'b1;
            for (int k = 0; k < b; k++) begin
                w_keep[b] = w_keep[b] & w_nz[k];
            end
        end
        for (int b = 0; b < NBYTES; b++) begin
            o_text[b*BYTE_W +: BYTE_W] = w_keep[b] ? i_text[b*BYTE_W +: BYTE_W]
                                                   : {BYTE_W{1'b0}};
        end
    end

endmodule
